/* rtl/awve_pkg.sv */
// Shared constants, codes and control/status types of the velocity estimator.
`default_nettype none
package awve_pkg;
  localparam int HIST_DEPTH = 16;
  localparam int SLOT_W = $clog2(HIST_DEPTH);
  localparam int DEPTH_CAP = (HIST_DEPTH > 16) ? 16 : HIST_DEPTH;
  localparam int CNT_W = $clog2(DEPTH_CAP + 1);
  localparam int WIN_W = 4;
  localparam int POS_W = 32;
  localparam int VEL_W = 48;
  localparam int QUO_W = 49;

  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_BAND  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic             latch_in;
    logic             store_first;
    logic             store_new;
    logic [WIN_W-1:0] rd_back;
    logic             ld_start;
    logic             mul;
    logic             ld_vel;
    logic             div_start;
    logic [1:0]       axis;
    logic             div_capture;
    logic             load_out;
    logic [WIN_W-1:0] window;
  } cmd_t;

  typedef struct packed {
    logic             first;
    logic             stale;
    logic [WIN_W-1:0] last_back;
    logic             dev_fail;
    logic             div_done;
    logic             out_busy;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/awve_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module awve_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [awve_pkg::QUO_W-1:0] num,
  input  wire logic [31:0]                den,
  output logic                            done,
  output logic [awve_pkg::QUO_W-1:0]      quo
);
  localparam int CW = $clog2(awve_pkg::QUO_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [awve_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [31:0]                rem_r, rem_nxt;
  logic [31:0]                den_r, den_nxt;
  logic [32:0]                shifted;
  logic [33:0]                trial;

  always_comb begin
    shifted  = {rem_r, q_r[awve_pkg::QUO_W-1]};
    trial    = {1'b0, shifted} - {2'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(awve_pkg::QUO_W);
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[awve_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        q_nxt   = {q_r[awve_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

/* rtl/awve_dp.sv */
// Datapath: sample history, band check arithmetic, velocity division and result word.
`default_nettype none
module awve_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire awve_pkg::cmd_t             cmd,
  output awve_pkg::stat_t                 stat,
  input  wire logic [4:0]                 depth,
  input  wire logic [30:0]                band,
  input  wire logic [31:0]                in_timestamp,
  input  wire logic signed [31:0]         in_pos_x,
  input  wire logic signed [31:0]         in_pos_y,
  input  wire logic signed [31:0]         in_pos_z,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [47:0]              out_vel_x,
  output logic signed [47:0]              out_vel_y,
  output logic signed [47:0]              out_vel_z,
  output logic [3:0]                      out_window_steps
);
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } entry_t;

  localparam logic [awve_pkg::CNT_W-1:0] CAP = awve_pkg::CNT_W'(awve_pkg::DEPTH_CAP);
  localparam logic signed [47:0] VMAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] VMIN = {1'b1, {47{1'b0}}};
  localparam logic [1:0] AXIS_SEL_Y = awve_pkg::AXIS_Y;
  localparam logic [1:0] AXIS_SEL_Z = awve_pkg::AXIS_Z;

  entry_t mem [awve_pkg::HIST_DEPTH];
  entry_t rdata_r;

  logic [31:0]        t_in_r;
  logic signed [31:0] x_in_r, y_in_r, z_in_r;
  logic [31:0]        newest_t_r;
  logic [awve_pkg::SLOT_W-1:0] slot_r, slot_nxt, rd_addr, wr_addr;
  logic [awve_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, eff_d, cnt_inc;
  logic                        wr_en;

  logic signed [31:0] xs_r;
  logic [31:0]        ts_r, period_r;
  logic signed [32:0] dx_r;
  logic signed [64:0] p1_r, p2_r;
  logic [62:0]        lim_r;
  logic signed [32:0] xd, dt_s, per_s;
  logic signed [65:0] dev;
  logic [65:0]        dev_abs;

  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [31:0] new_sel, old_sel;
  logic signed [32:0] diff;
  logic signed [48:0] numv;
  logic [48:0]        mag;
  logic               neg_r;
  logic               div_done;
  logic [48:0]        quo;
  logic signed [47:0] sat;
  logic signed [47:0] vx_r, vy_r, vz_r;
  logic               ov_r, ov_nxt;

  always_comb begin
    eff_d = (depth < 5'd2) ? awve_pkg::CNT_W'(2) : awve_pkg::CNT_W'(depth);
    if (depth > 5'(awve_pkg::DEPTH_CAP)) eff_d = CAP;
    cnt_inc = cnt_r + awve_pkg::CNT_W'(1);
    if (cnt_inc > eff_d) cnt_inc = eff_d;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    wr_addr  = slot_r;
    if (cmd.store_first) begin
      wr_en   = 1'b1;
      cnt_nxt = awve_pkg::CNT_W'(1);
    end else if (cmd.store_new) begin
      wr_en    = 1'b1;
      slot_nxt = slot_r + awve_pkg::SLOT_W'(1);
      wr_addr  = slot_nxt;
      cnt_nxt  = cnt_inc;
    end
    rd_addr = slot_r - awve_pkg::SLOT_W'(cmd.rd_back);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {t_in_r, x_in_r, y_in_r, z_in_r};
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    xd    = 33'(signed'(rdata_r.x)) - 33'(xs_r);
    dt_s  = signed'({1'b0, rdata_r.t - ts_r});
    per_s = signed'({1'b0, period_r});
    dev   = 66'(p1_r) - 66'(p2_r);
    dev_abs = dev[65] ? 66'(-dev) : 66'(dev);
  end

  always_comb begin
    unique case (cmd.axis)
      AXIS_SEL_Y: begin new_sel = y_in_r; old_sel = oy_r; end
      AXIS_SEL_Z: begin new_sel = z_in_r; old_sel = oz_r; end
      default:    begin new_sel = x_in_r; old_sel = ox_r; end
    endcase
    diff = 33'(new_sel) - 33'(old_sel);
    numv = {diff, 16'b0};
    mag  = numv[48] ? 49'(-numv) : 49'(numv);
    if (!neg_r && quo > 49'(VMAX)) sat = VMAX;
    else if (neg_r && quo > {2'b0, 47'b0} + 49'h800000000000) sat = VMIN;
    else if (neg_r) sat = 48'(-signed'(quo));
    else sat = 48'(quo);
  end

  awve_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (mag),
    .den   (period_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (cmd.load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
    if (cmd.latch_in) begin
      t_in_r <= in_timestamp;
      x_in_r <= in_pos_x;
      y_in_r <= in_pos_y;
      z_in_r <= in_pos_z;
    end
    if (wr_en) newest_t_r <= t_in_r;
    if (cmd.ld_start) begin
      xs_r     <= signed'(rdata_r.x);
      ts_r     <= rdata_r.t;
      period_r <= t_in_r - rdata_r.t;
      dx_r     <= 33'(x_in_r) - 33'(signed'(rdata_r.x));
    end
    if (cmd.mul) begin
      p1_r  <= xd * per_s;
      p2_r  <= dx_r * dt_s;
      lim_r <= band * period_r;
    end
    if (cmd.ld_vel) begin
      ox_r     <= signed'(rdata_r.x);
      oy_r     <= signed'(rdata_r.y);
      oz_r     <= signed'(rdata_r.z);
      period_r <= t_in_r - rdata_r.t;
    end
    if (cmd.div_start) neg_r <= numv[48];
    if (cmd.div_capture) begin
      unique case (cmd.axis)
        awve_pkg::AXIS_Y: vy_r <= sat;
        awve_pkg::AXIS_Z: vz_r <= sat;
        default:          vx_r <= sat;
      endcase
    end
    if (cmd.load_out) begin
      out_vel_x        <= vx_r;
      out_vel_y        <= vy_r;
      out_vel_z        <= vz_r;
      out_window_steps <= cmd.window;
    end
  end

  always_comb begin
    stat.first     = (cnt_r == '0);
    stat.stale     = (t_in_r <= newest_t_r);
    stat.last_back = awve_pkg::WIN_W'(cnt_r - awve_pkg::CNT_W'(1));
    stat.dev_fail  = (dev_abs > {3'b0, lim_r});
    stat.div_done  = div_done;
    stat.out_busy  = ov_r;
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

/* rtl/awve_ctrl.sv */
// Controller: sequences storing, the window search, the divisions and the result hand-off.
`default_nettype none
module awve_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire awve_pkg::stat_t stat,
  output awve_pkg::cmd_t       cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_SRD    = 4'd2;
  localparam logic [3:0] S_SLD    = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_VRD    = 4'd6;
  localparam logic [3:0] S_VLD    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_DWAIT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam int W = awve_pkg::WIN_W;

  logic [3:0]   state_r, state_nxt;
  logic [W-1:0] back_r, back_nxt, k_r, k_nxt, chosen_r, chosen_nxt;
  logic [1:0]   axis_r, axis_nxt;

  always_comb begin
    state_nxt  = state_r;
    back_nxt   = back_r;
    k_nxt      = k_r;
    chosen_nxt = chosen_r;
    axis_nxt   = axis_r;
    cmd        = '0;
    cmd.axis   = axis_r;
    cmd.window = chosen_r;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.first) begin
          cmd.store_first = 1'b1;
          state_nxt       = S_IDLE;
        end else if (stat.stale) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.store_new = 1'b1;
          back_nxt      = W'(1);
          chosen_nxt    = W'(1);
          state_nxt     = S_SRD;
        end
      end
      S_SRD: begin
        cmd.rd_back = back_r;
        state_nxt   = S_SLD;
      end
      S_SLD: begin
        cmd.ld_start = 1'b1;
        if (back_r == W'(1)) begin
          if (back_r == stat.last_back) begin
            state_nxt = S_VRD;
          end else begin
            back_nxt  = back_r + W'(1);
            state_nxt = S_SRD;
          end
        end else begin
          k_nxt       = back_r - W'(1);
          cmd.rd_back = back_r - W'(1);
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.dev_fail) begin
          state_nxt = S_VRD;
        end else if (k_r == W'(1)) begin
          chosen_nxt = back_r;
          if (back_r == stat.last_back) begin
            state_nxt = S_VRD;
          end else begin
            back_nxt  = back_r + W'(1);
            state_nxt = S_SRD;
          end
        end else begin
          k_nxt       = k_r - W'(1);
          cmd.rd_back = k_r - W'(1);
          state_nxt   = S_MUL;
        end
      end
      S_VRD: begin
        cmd.rd_back = chosen_r;
        state_nxt   = S_VLD;
      end
      S_VLD: begin
        cmd.ld_vel = 1'b1;
        axis_nxt   = awve_pkg::AXIS_X;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_capture = 1'b1;
          if (axis_r == awve_pkg::AXIS_Z) begin
            state_nxt = S_OUT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIV;
          end
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      back_r   <= '0;
      k_r      <= '0;
      chosen_r <= '0;
      axis_r   <= awve_pkg::AXIS_X;
    end else begin
      state_r  <= state_nxt;
      back_r   <= back_nxt;
      k_r      <= k_nxt;
      chosen_r <= chosen_nxt;
      axis_r   <= axis_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/adaptive_window_velocity_estimator.sv */
// Top level: configuration registers, controller and datapath of the velocity estimator.
// Timestamped Q16.16 positions enter one word at a time; each sample newer than the last
// stored one yields a word of x/y/z velocity (Q16.32 per tick, truncated, saturated) over
// the longest window back, grown one step at a time, whose inner samples stay in the band
// of the x line; the search stops at the first window that fails. The first sample after
// reset and samples not later than the newest stored one give no result. At depth 16 up to
// 15 window starts are tried and up to 105 inner-sample checks made; the checks read one
// history entry each through the single read port of the history memory, and the three
// divisions run one after another on one bit-serial divider. A finished word waits in the
// output register while the next sample is taken.
`default_nettype none
module adaptive_window_velocity_estimator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_timestamp,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      out_vel_x,
  output logic signed [47:0]      out_vel_y,
  output logic signed [47:0]      out_vel_z,
  output logic [3:0]              out_window_steps,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  awve_pkg::cmd_t  cmd;
  awve_pkg::stat_t stat;
  logic [4:0]      depth_r;
  logic [30:0]     band_r;
  logic            wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 5'd16;
      band_r  <= 31'd65536;
    end else if (wr) begin
      unique case (paddr[2])
        awve_pkg::REG_DEPTH: depth_r <= pwdata[4:0];
        default:             band_r  <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      awve_pkg::REG_DEPTH: prdata = {27'b0, depth_r};
      default:             prdata = {1'b0, band_r};
    endcase
  end

  awve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  awve_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .depth            (depth_r),
    .band             (band_r),
    .in_timestamp     (in_timestamp),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vel_x        (out_vel_x),
    .out_vel_y        (out_vel_y),
    .out_vel_z        (out_vel_z),
    .out_window_steps (out_window_steps)
  );
endmodule
`default_nettype wire
